// ===== design/silt_pkg.sv =====
// Package for the sorted interval lookup table: payload types, FSM states, commands.
// No dependencies.
`default_nettype none
package silt_pkg;

    localparam int unsigned TableDepthDefault = 64;

    localparam logic CmdLookup = 1'b0;
    localparam logic CmdInsert = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] probe_address;
        logic [63:0] range_start;
        logic [63:0] range_last;
        logic [31:0] name_handle;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [63:0] distance;
        logic [31:0] result_name;
        logic        table_full;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WAIT,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request, set bounds
        logic rd;         // read memory at mid
        logic step;       // apply compare result to bounds
        logic shift_rd;   // read entry at shift index minus one
        logic shift_wr;   // write read data to shift index, decrement
        logic place;      // write new entry at lo
        logic rsp_hit;    // latch hit response
        logic rsp_miss;   // latch miss response
        logic rsp_ins;    // latch insert response
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_insert;
        logic search_done;  // lo >= hi
        logic hit;          // lookup compare hit at mid
        logic full;
        logic shift_done;   // shift index equals lo
    } t_sts;

endpackage
`default_nettype wire

// ===== design/silt_ctrl.sv =====
// Controller state machine for the sorted interval lookup table.
// Depends on silt_pkg.
`default_nettype none
module silt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire logic            i_rsp_busy,
    input  wire silt_pkg::t_sts  i_sts,
    output silt_pkg::t_cmd       o_cmd
);

    silt_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= silt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            silt_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = silt_pkg::ST_RD;
                end
            end
            silt_pkg::ST_RD: begin
                if (i_sts.is_insert && i_sts.full) begin
                    n_state = silt_pkg::ST_DONE;
                end else if (i_sts.search_done) begin
                    n_state = i_sts.is_insert ? silt_pkg::ST_SHIFT_RD : silt_pkg::ST_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = silt_pkg::ST_WAIT;
                end
            end
            silt_pkg::ST_WAIT: begin
                n_state = silt_pkg::ST_CMP;
            end
            // On a hit the read data stays put, so wait here for the output slot.
            silt_pkg::ST_CMP: begin
                if (!i_sts.is_insert && i_sts.hit) begin
                    if (!i_rsp_busy) begin
                        o_cmd.rsp_hit = 1'b1;
                        n_state       = silt_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = silt_pkg::ST_RD;
                end
            end
            silt_pkg::ST_SHIFT_RD: begin
                if (i_sts.shift_done) begin
                    o_cmd.place = 1'b1;
                    n_state     = silt_pkg::ST_DONE;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = silt_pkg::ST_SHIFT_WAIT;
                end
            end
            silt_pkg::ST_SHIFT_WAIT: begin
                n_state = silt_pkg::ST_SHIFT_WR;
            end
            silt_pkg::ST_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = silt_pkg::ST_SHIFT_RD;
            end
            silt_pkg::ST_DONE: begin
                if (!i_rsp_busy) begin
                    if (i_sts.is_insert) begin
                        o_cmd.rsp_ins = 1'b1;
                    end else begin
                        o_cmd.rsp_miss = 1'b1;
                    end
                    n_state = silt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = silt_pkg::ST_IDLE;
            end
        endcase
    end

    // Hit response is issued only from a compare.
    a_hit_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rsp_hit |-> r_state == silt_pkg::ST_CMP)
        else $error("hit response outside compare");
    // Ready only while idle and loads only on a request.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (i_req_valid && o_req_ready))
        else $error("load without request");
    // A memory read is always followed by a wait state.
    a_rd_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> r_state == silt_pkg::ST_WAIT)
        else $error("read not followed by wait");

endmodule
`default_nettype wire

// ===== design/silt_dp.sv =====
// Datapath for the sorted interval lookup table: entry memory, search bounds, response.
// Depends on silt_pkg.
`default_nettype none
module silt_dp #(
    parameter int unsigned TABLE_DEPTH = silt_pkg::TableDepthDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire silt_pkg::t_req  i_req,
    input  wire silt_pkg::t_cmd  i_cmd,
    output silt_pkg::t_sts       o_sts,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output silt_pkg::t_rsp       o_rsp
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

    // Entry memory: start, last, name packed in one word.
    logic [159:0] r_mem [TABLE_DEPTH];
    logic [159:0] r_rd;

    silt_pkg::t_req r_req;
    logic [CW-1:0]  r_count, r_lo, r_hi, r_idx;
    logic           r_drop;
    logic [CW-1:0]  mid;
    logic [63:0]    e_start, e_last;
    logic [31:0]    e_name;
    logic           lt_start, le_last, go_right;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign e_start  = r_rd[159:96];
    assign e_last   = r_rd[95:32];
    assign e_name   = r_rd[31:0];
    assign lt_start = r_req.probe_address < e_start;
    assign le_last  = r_req.probe_address <= e_last;
    assign go_right = (r_req.command == silt_pkg::CmdInsert) ?
                      (e_start <= r_req.range_start) : !lt_start;

    assign o_sts.is_insert   = r_req.command == silt_pkg::CmdInsert;
    assign o_sts.search_done = r_lo >= r_hi;
    assign o_sts.hit         = !lt_start && le_last;
    assign o_sts.full        = r_count >= DepthC;
    assign o_sts.shift_done  = r_idx == r_lo;

    // Memory port: one read, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[mid[AW-1:0]];
        end else if (i_cmd.shift_rd) begin
            r_rd <= r_mem[AW'(r_idx - CW'(1))];
        end
        if (i_cmd.shift_wr) begin
            r_mem[r_idx[AW-1:0]] <= r_rd;
        end else if (i_cmd.place) begin
            r_mem[r_lo[AW-1:0]] <= {r_req.range_start, r_req.range_last, r_req.name_handle};
        end
    end

    // Request capture, bounds and shift index. The table-full flag is taken
    // at the start so that filling the last slot does not report a drop.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_lo   <= '0;
            r_hi   <= r_count;
            r_idx  <= r_count;
            r_drop <= r_count >= DepthC;
        end
        if (i_cmd.step) begin
            if (go_right) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_wr) begin
            r_idx <= r_idx - CW'(1);
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.place) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp_valid <= 1'b0;
        end else if (i_cmd.rsp_hit || i_cmd.rsp_miss || i_cmd.rsp_ins) begin
            o_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            o_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rsp_hit) begin
            o_rsp <= '{found: 1'b1, distance: r_req.probe_address - e_start,
                       result_name: e_name, table_full: 1'b0};
        end else if (i_cmd.rsp_miss) begin
            o_rsp <= '0;
        end else if (i_cmd.rsp_ins) begin
            o_rsp <= '{found: 1'b1, distance: r_req.probe_address - r_req.range_start,
                       result_name: r_req.name_handle, table_full: r_drop};
        end
    end

    // Count never exceeds the depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DepthC) else $error("count over depth");
    // Never place into a full table.
    a_place_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> !o_sts.full) else $error("place into full table");
    // Search bounds stay ordered.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_lo < r_hi) else $error("read with empty range");

endmodule
`default_nettype wire

// ===== design/sorted_interval_lookup_table.sv =====
// Top level of the sorted interval lookup table; ties controller and datapath.
// Depends on silt_pkg, silt_ctrl, silt_dp.
// One request at a time. A lookup runs a binary search; each memory probe passes
// through read, registered data and compare. A full search takes log2(depth)+1
// probes before a miss is registered; a hit ends at its compare. An insert into a
// full table is dropped without a search; any other insert searches the same way
// and then moves every later entry up one place through the single memory port,
// with a read, a wait and a write for each moved entry. The result sits in an output
// register; the next request is taken once the result is registered, and a result
// waiting in that register holds the next result back until it is taken.
`default_nettype none
module sorted_interval_lookup_table #(
    parameter int unsigned TABLE_DEPTH = silt_pkg::TableDepthDefault
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire silt_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output silt_pkg::t_rsp       o_rsp
);

    silt_pkg::t_cmd cmd;
    silt_pkg::t_sts sts;
    logic           rsp_busy;

    assign rsp_busy = o_rsp_valid && !i_rsp_ready;

    silt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_rsp_busy  (rsp_busy),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    silt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the sorted interval lookup table: random and directed requests,
// an in-bench model of the sorted range table, and a field-by-field response check.
// Depends on silt_pkg and sorted_interval_lookup_table.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 64;
    localparam int StallLimit = 20000;
    localparam int DrainCycles = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    silt_pkg::t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    silt_pkg::t_rsp o_rsp;

    sorted_interval_lookup_table #(.TABLE_DEPTH(Depth)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // Model state of the range table.
    logic [63:0] tbl_start [Depth];
    logic [63:0] tbl_last [Depth];
    logic [31:0] tbl_name [Depth];
    int          tbl_count = 0;

    silt_pkg::t_req pending_reqs[$];
    silt_pkg::t_rsp expected_rsps[$];
    int   mismatches = 0;
    int   hold_cycles = 0;

    // Apply one request to the model and return the response it should produce.
    function automatic silt_pkg::t_rsp resolve_request(silt_pkg::t_req r);
        silt_pkg::t_rsp res;
        int lo, hi, mid;
        res = '0;
        lo = 0;
        hi = tbl_count;
        if (r.command == silt_pkg::CmdInsert) begin
            res.found = 1'b1;
            res.distance = r.probe_address - r.range_start;
            res.result_name = r.name_handle;
            if (tbl_count >= Depth) begin
                res.table_full = 1'b1;
            end else begin
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_start[mid] <= r.range_start) lo = mid + 1;
                    else hi = mid;
                end
                for (int i = tbl_count; i > lo; i--) begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_last[i] = tbl_last[i-1];
                    tbl_name[i] = tbl_name[i-1];
                end
                tbl_start[lo] = r.range_start;
                tbl_last[lo] = r.range_last;
                tbl_name[lo] = r.name_handle;
                tbl_count++;
            end
        end else begin
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (r.probe_address < tbl_start[mid]) begin
                    hi = mid;
                end else if (r.probe_address <= tbl_last[mid]) begin
                    res.found = 1'b1;
                    res.distance = r.probe_address - tbl_start[mid];
                    res.result_name = tbl_name[mid];
                    return res;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Append one request to the pending queue.
    task automatic queue_req(silt_pkg::t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic silt_pkg::t_req make_req(logic cmd, logic [63:0] pc, logic [63:0] s,
                                                logic [63:0] l, logic [31:0] nm);
        silt_pkg::t_req r;
        r.command = cmd;
        r.probe_address = pc;
        r.range_start = s;
        r.range_last = l;
        r.name_handle = nm;
        return r;
    endfunction

    // Random request clustered in a small address window so lookups often hit.
    function automatic silt_pkg::t_req random_req(int insert_pct);
        logic [63:0] base, s, len;
        base = ($urandom_range(0, 9) == 0) ? rand64() : 64'h4000_0000 + $urandom_range(0, 4095);
        s = base;
        len = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 300));
        if ($urandom_range(0, 19) == 0) len = ~len; // sometimes an inverted range
        return make_req(($urandom_range(0, 99) < insert_pct) ? silt_pkg::CmdInsert
                                                              : silt_pkg::CmdLookup,
                        ($urandom_range(0, 9) == 0) ? rand64()
                            : 64'h4000_0000 + $urandom_range(0, 4400),
                        s, s + len, $urandom);
    endfunction

    // Request driver: random gaps, valid held until accepted.
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            expected_rsps = {expected_rsps, resolve_request(i_req)};
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap == 0 && pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
            end else begin
                i_req_valid <= 1'b0;
            end
        end else if (!i_req_valid) begin
            if (gap > 0) begin
                gap--;
            end else if (pending_reqs.size() > 0) begin
                i_req_valid <= 1'b1;
                i_req <= pending_reqs.pop_front();
            end
        end
    end

    // Response monitor with random stalls and an optional long hold-off.
    int rsp_wait = 0;
    silt_pkg::t_rsp want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response", 64'(o_rsp.found), 64'd0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.found !== want.found)
                        report_mismatch("found", 64'(o_rsp.found), 64'(want.found));
                    if (o_rsp.distance !== want.distance)
                        report_mismatch("distance", o_rsp.distance, want.distance);
                    if (o_rsp.result_name !== want.result_name)
                        report_mismatch("result_name", 64'(o_rsp.result_name),
                                        64'(want.result_name));
                    if (o_rsp.table_full !== want.table_full)
                        report_mismatch("table_full", 64'(o_rsp.table_full),
                                        64'(want.table_full));
                end
                rsp_wait = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) rsp_wait = 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_rsp_ready <= 1'b0;
            end else if (rsp_wait > 0) begin
                rsp_wait--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted request or response.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("Watchdog expired at %0t", $realtime);
            $display("** sorted_interval_lookup_table: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_req_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        // Directed: lookup on an empty table, extremes, inverted and overlapping ranges.
        queue_req(make_req(silt_pkg::CmdLookup, '0, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, '1, '1, '1, '1));
        queue_req(make_req(silt_pkg::CmdInsert, 64'h100, 64'h100, 64'h1ff, 32'hA));
        queue_req(make_req(silt_pkg::CmdInsert, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF));
        queue_req(make_req(silt_pkg::CmdInsert, '1, 64'hFFFF_FFFF_FFFF_FF00, '1, 32'h1));
        queue_req(make_req(silt_pkg::CmdInsert, 64'h10, 64'h500, 64'h400, 32'hB));
        queue_req(make_req(silt_pkg::CmdInsert, 64'h180, 64'h100, 64'h300, 32'hC));
        queue_req(make_req(silt_pkg::CmdInsert, 64'h5, 64'h180, 64'h190, 32'hD));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h0, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h100, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h1ff, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h250, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h185, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h450, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, '1, '0, '0, '0));
        queue_req(make_req(silt_pkg::CmdLookup, 64'h8000_0000_0000_0000, '0, '0, '0));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // Fill the table past full while the receiver holds off for a long stretch.
        hold_cycles = 600;
        for (int i = 0; i < 90; i++) queue_req(random_req(85));
        wait_drained();
        for (int i = 0; i < 300; i++) queue_req(random_req(5));
        wait_drained();

        // The table stays full from here on, so the remaining random traffic
        // probes a full table and every insert is dropped.
        for (int i = 0; i < 1300; i++) begin
            queue_req(random_req(10));
            if (i % 400 == 399) wait_drained();
        end
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("** sorted_interval_lookup_table: PASSED **");
        end else begin
            $display("** sorted_interval_lookup_table: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
